// ===== rtl/phcd_pkg.sv =====
// shared types and constants for the packet header checksum deframer
package phcd_pkg;

  localparam logic [15:0] HDR_BYTES   = 16'd14;
  localparam logic [15:0] CKS_HI_POS  = 16'd10;
  localparam logic [15:0] CKS_LO_POS  = 16'd11;
  localparam logic [15:0] INDEX_MAX   = 16'hFFFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        pay;
    logic        summ;
    logic [7:0]  data_byte;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] seq;
    logic [12:0] plen;
    logic [15:0] sum;
    logic [15:0] rx_chk;
    logic        short_pkt;
  } q_entry_t;

endpackage

// ===== rtl/phcd_front.sv =====
// front end: accepts bytes, captures the header, keeps the checksum, queues result work
module phcd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic               queue_full,
  output logic               push,
  output phcd_pkg::q_entry_t push_entry
);
  import phcd_pkg::*;

  logic [15:0] byte_index;
  logic [15:0] running_sum;
  logic [7:0]  pending_high;
  logic        half;
  logic [31:0] src_reg;
  logic [31:0] dst_reg;
  logic [15:0] seq_reg;
  logic [15:0] rx_checksum;
  logic [15:0] len_bits;

  logic [31:0] src_next;
  logic [31:0] dst_next;
  logic [15:0] seq_next;
  logic [15:0] chk_next;
  logic [15:0] len_next;
  logic [15:0] sum_next;
  logic [7:0]  sum_b;
  logic [15:0] word;
  logic        add_en;
  logic [16:0] sum_ext;
  logic [15:0] sum_add;
  logic        accept;
  logic        pay;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    src_next = src_reg;
    dst_next = dst_reg;
    seq_next = seq_reg;
    chk_next = rx_checksum;
    len_next = len_bits;
    if (byte_index < HDR_BYTES) begin
      case (byte_index[3:0])
        4'd0:    src_next[31:24] = data_byte;
        4'd1:    src_next[23:16] = data_byte;
        4'd2:    src_next[15:8]  = data_byte;
        4'd3:    src_next[7:0]   = data_byte;
        4'd4:    dst_next[31:24] = data_byte;
        4'd5:    dst_next[23:16] = data_byte;
        4'd6:    dst_next[15:8]  = data_byte;
        4'd7:    dst_next[7:0]   = data_byte;
        4'd8:    seq_next[15:8]  = data_byte;
        4'd9:    seq_next[7:0]   = data_byte;
        4'd10:   chk_next[15:8]  = data_byte;
        4'd11:   chk_next[7:0]   = data_byte;
        4'd12:   len_next[15:8]  = data_byte;
        4'd13:   len_next[7:0]   = data_byte;
        default: len_next = len_bits;
      endcase
    end
  end

  // checksum word goes in as zero
  assign sum_b = (byte_index == CKS_HI_POS || byte_index == CKS_LO_POS) ? 8'd0 : data_byte;

  always_comb begin
    if (half) begin
      word   = {pending_high, sum_b};
      add_en = 1'b1;
    end else if (last) begin
      word   = {8'd0, sum_b};
      add_en = 1'b1;
    end else begin
      word   = 16'd0;
      add_en = 1'b0;
    end
  end

  // end-around carry
  assign sum_ext  = {1'b0, running_sum} + {1'b0, word};
  assign sum_add  = sum_ext[16] ? (sum_ext[15:0] + 16'd1) : sum_ext[15:0];
  assign sum_next = add_en ? sum_add : running_sum;

  assign pay = (byte_index >= HDR_BYTES) &&
               ((byte_index - HDR_BYTES) < {3'd0, len_bits[15:3]});

  assign push = accept && (pay || last);

  always_comb begin
    push_entry.pay       = pay;
    push_entry.summ      = last;
    push_entry.data_byte = data_byte;
    push_entry.src       = src_next;
    push_entry.dst       = dst_next;
    push_entry.seq       = seq_next;
    push_entry.plen      = len_next[15:3];
    push_entry.sum       = sum_next;
    push_entry.rx_chk    = chk_next;
    push_entry.short_pkt = byte_index < (HDR_BYTES - 16'd1);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      byte_index   <= '0;
      running_sum  <= '0;
      pending_high <= '0;
      half         <= 1'b0;
      src_reg      <= '0;
      dst_reg      <= '0;
      seq_reg      <= '0;
      rx_checksum  <= '0;
      len_bits     <= '0;
    end else if (accept) begin
      if (byte_index != INDEX_MAX) begin
        byte_index <= byte_index + 16'd1;
      end
      running_sum  <= sum_next;
      pending_high <= half ? 8'd0 : sum_b;
      half         <= !half;
      src_reg      <= src_next;
      dst_reg      <= dst_next;
      seq_reg      <= seq_next;
      rx_checksum  <= chk_next;
      len_bits     <= len_next;
    end
  end

endmodule

// ===== rtl/phcd_queue.sv =====
// small fifo of pending result work between front and back
module phcd_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  phcd_pkg::q_entry_t push_entry,
  input  logic               pop,
  output phcd_pkg::q_entry_t head,
  output logic               full,
  output logic               empty
);
  import phcd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/phcd_back.sv =====
// back end: turns queued work into payload and summary results
module phcd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               queue_empty,
  input  phcd_pkg::q_entry_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [7:0]         payload_byte,
  output logic [31:0]        source_addr,
  output logic [31:0]        dest_addr,
  output logic [15:0]        sequence_res,
  output logic [12:0]        payload_len,
  output logic               checksum_ok,
  output logic               too_short,
  output logic               run_end
);
  import phcd_pkg::*;

  logic phase;
  logic load;
  logic emit_pay;
  logic cks_match;

  assign load      = !queue_empty && (!out_valid || out_ready);
  assign emit_pay  = head.pay && !phase;
  assign pop       = load && !(emit_pay && head.summ);
  assign cks_match = !head.short_pkt && ((~head.sum) == head.rx_chk);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      phase     <= emit_pay && head.summ;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_pay) begin
        kind         <= KIND_PAYLOAD;
        payload_byte <= head.data_byte;
        source_addr  <= '0;
        dest_addr    <= '0;
        sequence_res <= '0;
        payload_len  <= '0;
        checksum_ok  <= 1'b0;
        too_short    <= 1'b0;
        run_end      <= !head.summ;
      end else begin
        kind         <= KIND_SUMMARY;
        payload_byte <= '0;
        source_addr  <= head.src;
        dest_addr    <= head.dst;
        sequence_res <= head.seq;
        payload_len  <= head.plen;
        checksum_ok  <= cks_match;
        too_short    <= head.short_pkt;
        run_end      <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/packet_header_checksum_deframer_core.sv =====
// top level of the packet header checksum deframer
// Takes one packet byte per cycle, back to back, as long as the internal queue has
// room. Each queue entry is loaded into the output register once that register is free.
// A byte makes at most one queue entry; the last byte of a packet that is also a
// payload byte makes two results from its one entry, a payload item and then a
// summary, so the output side is the limit: sustained input rate is one byte per cycle
// while the queue has room, and the extra result is absorbed by the QUEUE_DEPTH entry
// queue. The checksum path is one 16-bit add with end-around carry per byte pair, or
// for a lone last byte. No clearing pass after reset.
module packet_header_checksum_deframer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [31:0] source_addr,
  output logic [31:0] dest_addr,
  output logic [15:0] sequence_res,
  output logic [12:0] payload_len,
  output logic        checksum_ok,
  output logic        too_short,
  output logic        run_end
);
  import phcd_pkg::*;

  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;
  logic     queue_full;
  logic     queue_empty;

  phcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last       (last),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  phcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  phcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .source_addr  (source_addr),
    .dest_addr    (dest_addr),
    .sequence_res (sequence_res),
    .payload_len  (payload_len),
    .checksum_ok  (checksum_ok),
    .too_short    (too_short),
    .run_end      (run_end)
  );

endmodule

// ===== rtl/phcd_checker.sv =====
// port-level checks for the deframer, bound to the top level
module phcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [7:0]  payload_byte,
  input logic [31:0] source_addr,
  input logic [31:0] dest_addr,
  input logic [15:0] sequence_res,
  input logic [12:0] payload_len,
  input logic        checksum_ok,
  input logic        too_short,
  input logic        run_end
);
  import phcd_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_summary_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_SUMMARY) |-> run_end)
    else $error("summary without run_end");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PAYLOAD) |->
      (source_addr == '0 && dest_addr == '0 && sequence_res == '0 &&
       payload_len == '0 && !checksum_ok && !too_short))
    else $error("payload item carries summary fields");

  a_short_fails: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_short) |-> (!checksum_ok && kind == KIND_SUMMARY))
    else $error("short packet reported with good checksum");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(kind) && $stable(payload_byte) && $stable(run_end)))
    else $error("stalled result changed");

endmodule

bind packet_header_checksum_deframer_core phcd_checker u_phcd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .payload_byte (payload_byte),
  .source_addr  (source_addr),
  .dest_addr    (dest_addr),
  .sequence_res (sequence_res),
  .payload_len  (payload_len),
  .checksum_ok  (checksum_ok),
  .too_short    (too_short),
  .run_end      (run_end)
);

// ===== tb/packet_header_checksum_deframer_core_tb.sv =====
// testbench for the packet header checksum deframer: directed and random packets checked per item
`timescale 1ns / 100ps

module packet_header_checksum_deframer_core_tb;
  import phcd_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       lst;
  } byte_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pay;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] seq;
    logic [12:0] plen;
    logic        ok;
    logic        shrt;
    logic        rend;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [15:0] sequence_res;
  logic [12:0] payload_len;
  logic        checksum_ok;
  logic        too_short;
  logic        run_end;

  byte_item_t    tx_bytes[$];
  frame_result_t due_results[$];

  int   tx_gap = 0;
  int   rx_stall = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  bit   rx_hold = 1'b0;
  int   items_taken = 0;
  int   results_taken = 0;
  int   fail_count = 0;
  int   idle_cycles = 0;

  // predictor state
  logic [15:0] pos_idx = '0;
  logic [15:0] sum_acc = '0;
  logic [7:0]  hi_hold = '0;
  logic        odd_flag = 1'b0;
  logic [31:0] src_hdr = '0;
  logic [31:0] dst_hdr = '0;
  logic [15:0] seq_hdr = '0;
  logic [15:0] cks_hdr = '0;
  logic [15:0] len_hdr = '0;

  packet_header_checksum_deframer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .source_addr  (source_addr),
    .dest_addr    (dest_addr),
    .sequence_res (sequence_res),
    .payload_len  (payload_len),
    .checksum_ok  (checksum_ok),
    .too_short    (too_short),
    .run_end      (run_end)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] t;
    t = a + w;
    return t[16] ? t[15:0] + 16'd1 : t[15:0];
  endfunction

  // expected results of one accepted byte
  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    logic [15:0]   pos;
    logic [7:0]    sb;
    logic [12:0]   plen;
    logic          shrt;
    logic [15:0]   comp;
    int            p;
    frame_result_t r;
    pos = pos_idx;
    p = pos;
    sb = (pos == CKS_HI_POS || pos == CKS_LO_POS) ? 8'h00 : b;
    plen = len_hdr[15:3];
    if (pos < HDR_BYTES) begin
      if (p < 4) src_hdr[8*(3-p) +: 8] = b;
      else if (p < 8) dst_hdr[8*(7-p) +: 8] = b;
      else if (p < 10) seq_hdr[8*(9-p) +: 8] = b;
      else if (p < 12) cks_hdr[8*(11-p) +: 8] = b;
      else len_hdr[8*(13-p) +: 8] = b;
    end
    if (odd_flag) begin
      sum_acc = ones_add(sum_acc, {hi_hold, sb});
      odd_flag = 1'b0;
      hi_hold = 8'h00;
    end else if (lst) begin
      sum_acc = ones_add(sum_acc, {8'h00, sb});
    end else begin
      hi_hold = sb;
      odd_flag = 1'b1;
    end
    if (pos >= HDR_BYTES && (pos - HDR_BYTES) < {3'b000, plen}) begin
      r = '0;
      r.kind = KIND_PAYLOAD;
      r.pay = b;
      r.rend = !lst;
      due_results = {due_results, r};
    end
    if (pos != INDEX_MAX) pos_idx = pos + 16'd1;
    if (lst) begin
      shrt = pos < (HDR_BYTES - 16'd1);
      comp = 16'hFFFF - sum_acc;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.src = src_hdr;
      r.dst = dst_hdr;
      r.seq = seq_hdr;
      r.plen = len_hdr[15:3];
      r.ok = !shrt && comp == cks_hdr;
      r.shrt = shrt;
      r.rend = 1'b1;
      due_results = {due_results, r};
      pos_idx = '0;
      sum_acc = '0;
      hi_hold = '0;
      odd_flag = 1'b0;
      src_hdr = '0;
      dst_hdr = '0;
      seq_hdr = '0;
      cks_hdr = '0;
      len_hdr = '0;
    end
  endtask

  // queues one packet; keep > 0 cuts it down to that many bytes
  task automatic add_packet(input logic [31:0] s, input logic [31:0] d, input logic [15:0] q,
                            input logic [15:0] lb, input int body_len, input bit corrupt,
                            input int keep);
    logic [7:0]  pk[$];
    logic [15:0] acc;
    logic [15:0] cks;
    byte_item_t  it;
    for (int i = 0; i < 4; i++) pk = {pk, s[8*(3-i) +: 8]};
    for (int i = 0; i < 4; i++) pk = {pk, d[8*(3-i) +: 8]};
    pk = {pk, q[15:8]};
    pk = {pk, q[7:0]};
    pk = {pk, 8'h00};
    pk = {pk, 8'h00};
    pk = {pk, lb[15:8]};
    pk = {pk, lb[7:0]};
    repeat (body_len) pk = {pk, 8'($urandom)};
    acc = '0;
    for (int i = 0; i < pk.size(); i += 2)
      acc = ones_add(acc, (i + 1 < pk.size()) ? {pk[i], pk[i+1]} : {8'h00, pk[i]});
    cks = ~acc;
    if (corrupt) cks = cks ^ 16'($urandom_range(1, 65535));
    pk[10] = cks[15:8];
    pk[11] = cks[7:0];
    if (keep > 0)
      while (pk.size() > keep) pk.pop_back();
    for (int i = 0; i < pk.size(); i++) begin
      it.data = pk[i];
      it.lst = (i == pk.size() - 1);
      tx_bytes = {tx_bytes, it};
    end
  endtask

  // sender
  always @(posedge clk) begin : sender
    int         gap_left;
    byte_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      gap_left = tx_gap;
      if (in_valid && in_ready) begin
        deframe_byte(data_byte, last);
        items_taken <= items_taken + 1;
        gap_left = tx_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) tx_burst <= !tx_burst;
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && tx_bytes.size() > 0) begin
          nxt = tx_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          last <= nxt.lst;
          tx_gap <= 0;
        end else begin
          in_valid <= 1'b0;
          tx_gap <= (gap_left > 0) ? gap_left - 1 : 0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : receiver
    int            wait_left;
    frame_result_t got;
    frame_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall <= 0;
    end else begin
      wait_left = rx_stall;
      if (out_valid && out_ready) begin
        got.kind = kind;
        got.pay = payload_byte;
        got.src = source_addr;
        got.dst = dest_addr;
        got.seq = sequence_res;
        got.plen = payload_len;
        got.ok = checksum_ok;
        got.shrt = too_short;
        got.rend = run_end;
        if (due_results.size() == 0) begin
          want = 'x;
        end else begin
          want = due_results.pop_front();
        end
        if (got !== want) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("item %0d exp k=%0d b=%h s=%h d=%h q=%h l=%0d ok=%0d sh=%0d e=%0d",
                     results_taken, want.kind, want.pay, want.src, want.dst, want.seq,
                     want.plen, want.ok, want.shrt, want.rend);
          if (fail_count < 10)
            $display("item %0d got k=%0d b=%h s=%h d=%h q=%h l=%0d ok=%0d sh=%0d e=%0d",
                     results_taken, got.kind, got.pay, got.src, got.dst, got.seq,
                     got.plen, got.ok, got.shrt, got.rend);
        end
        results_taken <= results_taken + 1;
        wait_left = rx_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) rx_burst <= !rx_burst;
      end
      if (wait_left > 0) begin
        out_ready <= 1'b0;
        rx_stall <= wait_left - 1;
      end else begin
        out_ready <= !rx_hold;
        rx_stall <= 0;
      end
    end
  end

  // long receiver hold-offs so the block backs up into its input
  initial begin : rx_holdoff
    while (items_taken < 60) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
    while (items_taken < 250) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_seq
    int          pick;
    int          plen_r;
    int          body;
    logic [15:0] lb;

    // one-byte packet, header sum of all ones, payload byte that is also last
    add_packet(32'hFF00_0000, 32'h0, 16'h0, 16'h0, 0, 1'b0, 1);
    add_packet(32'hFFFF_0000, 32'h0, 16'h0, 16'h0, 0, 1'b0, 0);
    add_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h000F, 1, 1'b0, 0);

    while (tx_bytes.size() < 400) begin
      pick = $urandom_range(0, 9);
      plen_r = $urandom_range(0, 10);
      lb = 16'((plen_r << 3) | $urandom_range(0, 7));
      body = plen_r + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      if ($urandom_range(0, 7) == 0) begin
        lb = 16'($urandom);
        body = $urandom_range(0, 8);
      end
      add_packet($urandom, $urandom, 16'($urandom), lb, body, pick == 0,
                 (pick == 1) ? $urandom_range(1, 13) : 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/phcd_pkg.sv
rtl/phcd_front.sv
rtl/phcd_queue.sv
rtl/phcd_back.sv
rtl/packet_header_checksum_deframer_core.sv
rtl/phcd_checker.sv
tb/packet_header_checksum_deframer_core_tb.sv
